@@ hdl/ilp_pkg.sv @@
// Shared types, constants and the character classifier for the integer literal parser.
// No dependencies; every other file of the block depends on this package.
`default_nettype none
package ilp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int BASE_W          = 6;
  localparam int WORTH_W         = 6;

  localparam logic [BASE_W-1:0] START_BASE_RST = 6'd10;
  localparam logic [BASE_W-1:0] BASE_BIN       = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT       = 6'd8;
  localparam logic [BASE_W-1:0] BASE_HEX       = 6'd16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  typedef enum logic [1:0] {
    MOD_NONE = 2'd0,
    MOD_BIN  = 2'd1,
    MOD_OCT  = 2'd2,
    MOD_HEX  = 2'd3
  } ilp_mod_t;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_t;

  typedef struct packed {
    logic               is_end;
    logic               is_minus;
    logic               is_plus;
    ilp_mod_t           modifier;
    logic               is_digit;
    logic [WORTH_W-1:0] worth;
  } ilp_item_t;

  function automatic ilp_item_t ilp_classify(input logic op, input logic [7:0] c);
    ilp_item_t it;
    it.is_end   = op;
    it.is_minus = (c == CH_MINUS);
    it.is_plus  = (c == CH_PLUS);
    if (c == CH_LB || c == CH_UB) begin
      it.modifier = MOD_BIN;
    end else if (c == CH_LH || c == CH_UH) begin
      it.modifier = MOD_OCT;
    end else if (c == CH_LX || c == CH_UX) begin
      it.modifier = MOD_HEX;
    end else begin
      it.modifier = MOD_NONE;
    end
    it.is_digit = 1'b1;
    if (c >= CH_0 && c <= CH_9) begin
      it.worth = WORTH_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      it.worth = WORTH_W'(c - CH_LA + LETTER_OFS);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      it.worth = WORTH_W'(c - CH_UA + LETTER_OFS);
    end else begin
      it.is_digit = 1'b0;
      it.worth    = '0;
    end
    return it;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ilp_front.sv @@
// Front stage: takes input beats, classifies the character and holds it for the queue.
// Depends on ilp_pkg for the item type and the classifier.
`default_nettype none
module ilp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_char_code,
  input  wire logic               q_full,
  output      logic               q_push,
  output      ilp_pkg::ilp_item_t q_item
);
  import ilp_pkg::*;

  logic      front_v_r, front_v_nxt;
  ilp_item_t item_r;
  logic      accept;

  assign q_push   = front_v_r && !q_full;
  assign in_stall = front_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_item   = item_r;

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (q_push) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= ilp_classify(in_op, in_char_code);
    end
  end

endmodule
`default_nettype wire

@@ hdl/ilp_queue.sv @@
// Short FIFO of classified items between the front and back stages.
// Depends on ilp_pkg for the item type and the depth.
`default_nettype none
module ilp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ilp_pkg::ilp_item_t wr_item,
  input  wire logic               pop,
  output      ilp_pkg::ilp_item_t rd_item,
  output      logic               full,
  output      logic               empty
);
  import ilp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  ilp_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == DEPTH_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= PTR_W'((CNT_W'(wr_ptr_r) + CNT_W'(1)) % DEPTH_CNT);
      end
      if (do_pop) begin
        rd_ptr_r <= PTR_W'((CNT_W'(rd_ptr_r) + CNT_W'(1)) % DEPTH_CNT);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ilp_back.sv @@
// Back stage: parse state, base register, multiply-accumulate and the result register.
// Depends on ilp_pkg for the item type, base codes and reset constants.
`default_nettype none
module ilp_back #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ilp_pkg::BASE_W-1:0]    cfg_wr_data,
  input  wire logic                          q_empty,
  input  wire ilp_pkg::ilp_item_t            q_item,
  output      logic                          q_pop,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_ok,
  output      logic signed [VALUE_WIDTH-1:0] out_result_value,
  output      logic                          out_overflow
);
  import ilp_pkg::*;

  localparam int PROD_W = VALUE_WIDTH + BASE_W;

  logic [1:0]             pos_r, pos_nxt;
  sign_t                  sign_r, sign_nxt;
  logic                   zp_r, zp_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [BASE_W-1:0]      start_base_r;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   failed_r, failed_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   ok_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   ovf_out_r;

  logic                   digit_ok;
  logic                   mod_slot;
  logic [PROD_W-1:0]      prod;
  logic                   take_end;

  assign q_pop    = !q_empty && (!q_item.is_end || !out_valid_r || !out_stall);
  assign take_end = q_pop && q_item.is_end;
  assign digit_ok = q_item.is_digit && (q_item.worth < WORTH_W'(base_r));
  assign mod_slot = zp_r && ((pos_r == 2'd1) || (pos_r == 2'd2 && sign_r != SIGN_NONE));

  // acc * base + d; anything above the value width means overflow
  assign prod = ({{BASE_W{1'b0}}, acc_r} * {{VALUE_WIDTH{1'b0}}, base_r})
              + {{VALUE_WIDTH{1'b0}}, q_item.worth};

  always_comb begin
    pos_nxt    = pos_r;
    sign_nxt   = sign_r;
    zp_nxt     = zp_r;
    base_nxt   = base_r;
    acc_nxt    = acc_r;
    failed_nxt = failed_r;
    ovf_nxt    = ovf_r;
    if (q_pop && q_item.is_end) begin
      pos_nxt    = '0;
      sign_nxt   = SIGN_NONE;
      zp_nxt     = 1'b0;
      base_nxt   = start_base_r;
      acc_nxt    = '0;
      failed_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end else if (q_pop) begin
      if (!failed_r) begin
        if (pos_r == 2'd0) begin
          if (q_item.is_minus) begin
            sign_nxt = SIGN_MINUS;
          end else if (q_item.is_plus) begin
            sign_nxt = SIGN_PLUS;
          end else if (digit_ok) begin
            zp_nxt  = (q_item.worth == '0);
            acc_nxt = VALUE_WIDTH'(q_item.worth);
          end else begin
            failed_nxt = 1'b1;
          end
        end else if (pos_r == 2'd1 && sign_r != SIGN_NONE) begin
          if (digit_ok) begin
            zp_nxt  = (q_item.worth == '0);
            acc_nxt = VALUE_WIDTH'(q_item.worth);
          end else begin
            failed_nxt = 1'b1;
          end
        end else if (mod_slot && q_item.modifier != MOD_NONE) begin
          case (q_item.modifier)
            MOD_BIN: base_nxt = BASE_BIN;
            MOD_OCT: base_nxt = BASE_OCT;
            MOD_HEX: base_nxt = BASE_HEX;
            default: base_nxt = base_r;
          endcase
        end else if (digit_ok) begin
          acc_nxt = prod[VALUE_WIDTH-1:0];
          if (prod[PROD_W-1:VALUE_WIDTH] != '0) begin
            ovf_nxt = 1'b1;
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
      if (pos_r != 2'd3) begin
        pos_nxt = pos_r + 2'd1;
      end
    end
    // a base write between strings also reloads the working base
    if (cfg_wr_en && pos_r == 2'd0) begin
      base_nxt = cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take_end) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      sign_r       <= SIGN_NONE;
      zp_r         <= 1'b0;
      base_r       <= START_BASE_RST;
      start_base_r <= START_BASE_RST;
      acc_r        <= '0;
      failed_r     <= 1'b0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sign_r      <= sign_nxt;
      zp_r        <= zp_nxt;
      base_r      <= base_nxt;
      acc_r       <= acc_nxt;
      failed_r    <= failed_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        start_base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      ok_r      <= !failed_r;
      value_r   <= failed_r ? '0 : ((sign_r == SIGN_MINUS) ? (~acc_r + 1'b1) : acc_r);
      ovf_out_r <= !failed_r && ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = ok_r;
  assign out_result_value = $signed(value_r);
  assign out_overflow     = ovf_out_r;

endmodule
`default_nettype wire

@@ hdl/integer_literal_parser.sv @@
// Top level of the integer literal parser: front classifier, item queue, back parser.
// Depends on ilp_pkg, ilp_front, ilp_queue and ilp_back.
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_stall, in_op, in_char_code      | beats in
//  result  | out_valid, out_stall, out_ok,                | beats out
//          | out_result_value, out_overflow               |
//  config  | cfg_wr_en, cfg_wr_data                       | writes in
//
// One input beat per cycle while in_stall is low. A beat is registered in the front
// register, then written into the queue, and the back stage updates the parse state
// when it pops the item; an end beat's result is registered into the result register.
// The back stage's single multiply-add (value by base plus digit) sets the cycle.
// Reset (rst_n low, synchronous) clears the queue, the parse state and the
// result valid, and restores the start base to ten.
// A stalled result holds only end beats: characters flow on until an end beat heads the
// queue, and the queue then absorbs later beats until it fills and in_stall rises.
`default_nettype none
module integer_literal_parser #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ilp_pkg::BASE_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_char_code,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_ok,
  output      logic signed [VALUE_WIDTH-1:0] out_result_value,
  output      logic                          out_overflow
);
  import ilp_pkg::*;

  ilp_item_t front_item;
  ilp_item_t queue_item;
  logic      q_push, q_pop, q_full, q_empty;

  // classify each character and hold it until the queue has room
  ilp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (front_item)
  );

  // decouple the classifier from the parser so either side can stall alone
  ilp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (front_item),
    .pop     (q_pop),
    .rd_item (queue_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  // advance the parse state; drop a finished result into the output register
  ilp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_empty          (q_empty),
    .q_item           (queue_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_result_value (out_result_value),
    .out_overflow     (out_overflow)
  );

endmodule
`default_nettype wire

@@ hdl/ilp_checker.sv @@
// Port-level checks for the integer literal parser, bound to its top level.
// Depends on ilp_pkg for the default value width.
`default_nettype none
module ilp_checker #(
  parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_ok,
  input wire logic signed [VALUE_WIDTH-1:0] out_result_value,
  input wire logic                          out_overflow
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok)
      && $stable(out_result_value) && $stable(out_overflow))
    else $error("stalled result beat changed");

  // a failed string reports zero value and no overflow
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_result_value == '0 && !out_overflow)
    else $error("failed string carries a value or overflow");

  // leaving reset, no result is pending
  a_reset_out: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // leaving reset, the front stage is empty and takes a beat
  a_reset_in: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_stall)
    else $error("input stalled after reset");

endmodule

bind integer_literal_parser ilp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_ilp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_ok           (out_ok),
  .out_result_value (out_result_value),
  .out_overflow     (out_overflow)
);
`default_nettype wire
